FILE: rtl/core/mmfn_pkg.sv
// shared types and constants for the min-max feature normaliser
// no dependencies; imported by mmfn_div and min_max_feature_normalizer
`default_nettype none

package mmfn_pkg;

    localparam int MAX_FEATURES = 1024;
    localparam int MAX_VECTORS  = 256;
    localparam int FRAC_BITS    = 16;
    localparam int STORE_DEPTH  = MAX_VECTORS * MAX_FEATURES;

    localparam int FEAT_W    = $clog2(MAX_FEATURES);
    localparam int VEC_W     = $clog2(MAX_VECTORS + 1);
    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int NORM_W    = FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    localparam int VAL_W     = 8;
    localparam int FC_W      = 11;
    localparam int VEC_OUT_W = 8;
    localparam int FEAT_OUT_W = 10;

    localparam logic [FC_W-1:0] FC_RESET = 11'd784;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_WB,
        ST_READ_CHK,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] rem;
        logic [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/min_max_feature_normalizer.sv
// min-max feature normaliser top level: sample store, per-feature min/max memory, control
// depends on mmfn_pkg and mmfn_div
//
// channel   dir  signals                          word contents (lsb first)
// s (in)    in   i_s_tvalid/o_s_tready            tuser: cmd[1:0]; tdata: feature_value[7:0]
// m (out)   out  o_m_tvalid/i_m_tready            tdata: normalized_value[16:0],
//                                                  vector_index[7:0], feature_index[9:0], pad
//                                                  tlast: last_element
//                                                  tuser: empty_read, overflow
// cfg       in   i_cfg_wr_en                      i_cfg_wr_data: feature_count[10:0]
//
// load: sample write and min/max read, then min/max write-back
// read: emit if empty, else check, then the 16-step divider if needed, then emit
// clear and reset: sweep of all 1024 min/max entries, one entry a cycle, no word taken
// clear, load and reserved words give no result word; the output register holds a result
// until taken while the next word is accepted, and only a new result waits on it
`default_nettype none

module min_max_feature_normalizer
    import mmfn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire logic [7:0]       i_s_tdata,   // feature_value[7:0]
    input  wire logic [1:0]       i_s_tuser,   // cmd[1:0]
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    output logic [39:0]           o_m_tdata,   // normalized_value[16:0], vector_index[24:17],
                                               // feature_index[34:25], zero[39:35]
    output logic                  o_m_tlast,
    output logic [1:0]            o_m_tuser,   // empty_read[0], overflow[1]
    input  wire logic             i_cfg_wr_en,
    input  wire logic [FC_W-1:0]  i_cfg_wr_data
);

    localparam logic [NORM_W-1:0] ONE_FIX = NORM_W'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [FEAT_W-1:0]  r_clr_addr;
    logic [FC_W-1:0]    r_feature_count;
    logic [CNT_W-1:0]   r_load_count;
    logic [FEAT_W-1:0]  r_load_pos;
    logic [VEC_W-1:0]   r_load_vec;
    logic [CNT_W-1:0]   r_read_ptr;
    logic [FEAT_W-1:0]  r_read_pos;
    logic [VEC_W-1:0]   r_read_vec;
    logic               r_overflow;

    logic [VAL_W-1:0]   r_val;
    logic [FEAT_W-1:0]  r_mm_addr;

    logic [NORM_W-1:0]     r_res_norm;
    logic [VEC_OUT_W-1:0]  r_res_vec;
    logic [FEAT_OUT_W-1:0] r_res_feat;
    logic                  r_res_last;
    logic                  r_res_empty;
    logic                  r_res_ovf;

    logic                  r_out_valid;
    logic [NORM_W-1:0]     r_out_norm;
    logic [VEC_OUT_W-1:0]  r_out_vec;
    logic [FEAT_OUT_W-1:0] r_out_feat;
    logic                  r_out_last;
    logic                  r_out_empty;
    logic                  r_out_ovf;

    // sample store and {max, min} per feature
    logic [VAL_W-1:0]   sample_mem [STORE_DEPTH];
    logic [2*VAL_W-1:0] minmax_mem [MAX_FEATURES];
    logic [VAL_W-1:0]   r_sample_rd;
    logic [2*VAL_W-1:0] r_mm_rd;

    logic [FC_W-1:0]    eff_count;
    t_cmd               cmd;
    logic               in_acc;
    logic               load_full;
    logic               read_empty;
    logic               st_wr_en;
    logic               st_rd_en;
    logic               mm_rd_en;
    logic [FEAT_W-1:0]  mm_rd_addr;
    logic               mm_wr_en;
    logic [FEAT_W-1:0]  mm_wr_addr;
    logic [2*VAL_W-1:0] mm_wr_data;
    logic               out_load;
    logic               need_div;
    logic [VAL_W-1:0]   x_val, lo_val, hi_val;
    logic [VAL_W-1:0]   new_min, new_max;
    logic               load_wrap, read_wrap;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    function automatic logic pos_wraps(input logic [FEAT_W-1:0] pos,
                                       input logic [FC_W-1:0] cnt);
        return (FC_W'(pos) + FC_W'(1)) >= cnt;
    endfunction

    always_comb begin
        if (r_feature_count == '0) begin
            eff_count = FC_W'(1);
        end else if (r_feature_count > FC_W'(MAX_FEATURES)) begin
            eff_count = FC_W'(MAX_FEATURES);
        end else begin
            eff_count = r_feature_count;
        end
    end

    assign cmd        = t_cmd'(i_s_tuser);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign load_full  = (r_load_vec >= VEC_W'(MAX_VECTORS))
                     || (r_load_count >= CNT_W'(STORE_DEPTH));
    assign read_empty = r_read_ptr >= r_load_count;
    assign load_wrap  = pos_wraps(r_load_pos, eff_count);
    assign read_wrap  = pos_wraps(r_read_pos, eff_count);

    assign x_val    = r_sample_rd;
    assign lo_val   = r_mm_rd[VAL_W-1:0];
    assign hi_val   = r_mm_rd[2*VAL_W-1:VAL_W];
    assign need_div = (hi_val > lo_val) && (x_val > lo_val) && (x_val < hi_val);
    assign new_min  = (r_val < lo_val) ? r_val : lo_val;
    assign new_max  = (r_val > hi_val) ? r_val : hi_val;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == FEAT_W'(MAX_FEATURES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (cmd)
                        CMD_LOAD:  n_state = load_full ? ST_IDLE : ST_LOAD_WB;
                        CMD_READ:  n_state = read_empty ? ST_EMIT : ST_READ_CHK;
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_RSVD:  n_state = ST_IDLE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_WB:  n_state = ST_IDLE;
            ST_READ_CHK: n_state = need_div ? ST_DIV : ST_EMIT;
            ST_DIV: begin
                if (div_rsp.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control strobes
    always_comb begin
        o_s_tready    = 1'b0;
        st_wr_en      = 1'b0;
        st_rd_en      = 1'b0;
        mm_rd_en      = 1'b0;
        mm_rd_addr    = r_load_pos;
        mm_wr_en      = 1'b0;
        mm_wr_addr    = r_mm_addr;
        mm_wr_data    = {new_max, new_min};
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.rem   = x_val - lo_val;
        div_req.den   = hi_val - lo_val;
        unique case (r_state)
            ST_CLEAR: begin
                mm_wr_en   = 1'b1;
                mm_wr_addr = r_clr_addr;
                mm_wr_data = {{VAL_W{1'b0}}, {VAL_W{1'b1}}};
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (in_acc && cmd == CMD_LOAD && !load_full) begin
                    st_wr_en   = 1'b1;
                    mm_rd_en   = 1'b1;
                    mm_rd_addr = r_load_pos;
                end
                if (in_acc && cmd == CMD_READ && !read_empty) begin
                    st_rd_en   = 1'b1;
                    mm_rd_en   = 1'b1;
                    mm_rd_addr = r_read_pos;
                end
            end
            ST_LOAD_WB:  mm_wr_en = 1'b1;
            ST_READ_CHK: div_req.start = need_div;
            ST_DIV:      ;
            ST_EMIT:     out_load = !r_out_valid || i_m_tready;
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_wr_en) sample_mem[r_load_count[ADDR_W-1:0]] <= i_s_tdata;
        if (st_rd_en) r_sample_rd <= sample_mem[r_read_ptr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mm_wr_en) minmax_mem[mm_wr_addr] <= mm_wr_data;
        if (mm_rd_en) r_mm_rd <= minmax_mem[mm_rd_addr];
    end

    mmfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr_addr      <= '0;
            r_feature_count <= FC_RESET;
            r_load_count    <= '0;
            r_load_pos      <= '0;
            r_load_vec      <= '0;
            r_read_ptr      <= '0;
            r_read_pos      <= '0;
            r_read_vec      <= '0;
            r_overflow      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_feature_count <= i_cfg_wr_data;
            // sweep ends back at zero
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (in_acc) begin
                case (cmd)
                    CMD_LOAD: begin
                        if (load_full) begin
                            r_overflow <= 1'b1;
                        end else begin
                            r_load_count <= r_load_count + 1'b1;
                            r_load_pos   <= load_wrap ? '0 : r_load_pos + 1'b1;
                            if (load_wrap) r_load_vec <= r_load_vec + 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (!read_empty) begin
                            r_read_ptr <= r_read_ptr + 1'b1;
                            r_read_pos <= read_wrap ? '0 : r_read_pos + 1'b1;
                            if (read_wrap) r_read_vec <= r_read_vec + 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        r_load_count <= '0;
                        r_load_pos   <= '0;
                        r_load_vec   <= '0;
                        r_read_ptr   <= '0;
                        r_read_pos   <= '0;
                        r_read_vec   <= '0;
                        r_overflow   <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && cmd == CMD_LOAD) begin
            r_val     <= i_s_tdata;
            r_mm_addr <= r_load_pos;
        end
        if (in_acc && cmd == CMD_READ) begin
            r_res_ovf <= r_overflow;
            if (read_empty) begin
                r_res_norm  <= '0;
                r_res_vec   <= '0;
                r_res_feat  <= '0;
                r_res_last  <= 1'b0;
                r_res_empty <= 1'b1;
            end else begin
                r_res_vec   <= r_read_vec[VEC_OUT_W-1:0];
                r_res_feat  <= FEAT_OUT_W'(r_read_pos);
                r_res_last  <= (r_read_ptr + 1'b1) == r_load_count;
                r_res_empty <= 1'b0;
            end
        end
        if (r_state == ST_READ_CHK && !need_div) begin
            r_res_norm <= (hi_val > lo_val && x_val >= hi_val) ? ONE_FIX : '0;
        end
        if (r_state == ST_DIV && div_rsp.done) begin
            r_res_norm <= {1'b0, div_rsp.quot};
        end
        if (out_load) begin
            r_out_norm  <= r_res_norm;
            r_out_vec   <= r_res_vec;
            r_out_feat  <= r_res_feat;
            r_out_last  <= r_res_last;
            r_out_empty <= r_res_empty;
            r_out_ovf   <= r_res_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_feat, r_out_vec, r_out_norm};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_empty};

`ifndef SYNTHESIS
    a_read_behind_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_ptr <= r_load_count)
        else $error("read pointer passed load count");

    a_vec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_vec <= VEC_W'(MAX_VECTORS))
        else $error("vector counter out of bounds");

    a_clear_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && cmd == CMD_CLEAR) |=>
            (r_state == ST_CLEAR && r_load_count == '0 && !r_overflow))
        else $error("clear did not restart the set");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_norm <= ONE_FIX && (!r_out_empty || r_out_norm == '0)))
        else $error("normalised value out of range");

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_state == ST_DIV)
        else $error("divider finished outside the divide state");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mmfn_div.sv
// bit-serial restoring divider for the fraction (rem << FRAC_BITS) / den, rem < den
// depends on mmfn_pkg for widths and request / response structs
`default_nettype none

module mmfn_div
    import mmfn_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W-1:0]     r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [VAL_W:0]       shifted;
    logic                 fits;

    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.rem;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? VAL_W'(shifted - {1'b0, r_den}) : shifted[VAL_W-1:0];
            r_quot <= {r_quot[FRAC_BITS-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire
